FILE: hw/rtl/ept_pkg.sv
// Package for the encoder period tachometer: widths, register indexes,
// phase and controller state codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package ept_pkg;

  localparam int PERIOD_BITS = 26;
  localparam int PPR_W       = 12;
  localparam int TMO_W       = 24;
  localparam int TPM_W       = 26;
  localparam int RPM_W       = 26;
  localparam int CFG_W       = 26;
  localparam int IDX_W       = 2;
  localparam int PRODW       = PERIOD_BITS + PPR_W;
  localparam int CNT_W       = $clog2(TPM_W);

  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(330);
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(2000000);
  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(60000000);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

  localparam logic [IDX_W-1:0] REG_PPR = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_TMO = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TPM = IDX_W'(2);

  typedef enum logic [1:0] {
    PH_WAIT_HIGH0,
    PH_WAIT_FALL0,
    PH_WAIT_HIGH1,
    PH_WAIT_FALL1
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic step;
    logic mul;
    logic div_step;
    logic out_tmo;
    logic out_meas;
  } cmd_t;

  typedef struct packed {
    logic tmo;
    logic meas;
    logic div_last;
  } status_t;

endpackage

FILE: hw/rtl/encoder_period_tachometer_core.sv
// Encoder period tachometer, top level: controller plus datapath.
// Depends on ept_pkg, ept_ctrl, ept_datapath.
//
// Usage:
//   Each input item is one timebase tick carrying the sampled encoder line.
//   The block waits for high, first fall, high, second fall, counting ticks
//   between the falls, and emits rpm = ticks_per_minute / (period * ppr).
//   A phase that lasts past timeout_ticks emits rpm 0 with timed_out set.
//   Channels: in_valid_i/in_ready_o with encoder_level_i; out_valid_o/
//   out_ready_i with rpm_o and timed_out_o. Config: cfg_we_i, cfg_index_i,
//   cfg_data_i; the user must write these only while idle (not enforced by the block).
//   Flow: a tick that gives no result or a timeout is taken in the idle
//   state. A tick that completes a measurement goes through a multiply
//   state, the bit-serial divider and an output load that waits for a free
//   output register; rpm_o is valid on the cycle after the load.
//   A held result stays in the output register until taken; while it is
//   held and out_ready_i is low, in_ready_o is low.
//   Reset: phase returns to wait-for-high, phase and tick counters clear, registers take
//   330 / 2000000 / 60000000 and no result is pending.
`timescale 1ns / 1ps

module encoder_period_tachometer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ept_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [ept_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       encoder_level_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ept_pkg::RPM_W-1:0]  rpm_o,
  output logic                       timed_out_o
);
  import ept_pkg::*;

  cmd_t    cmd;
  status_t st;

  ept_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ept_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .encoder_level_i (encoder_level_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .rpm_o           (rpm_o),
    .timed_out_o     (timed_out_o)
  );

endmodule

FILE: hw/rtl/ept_ctrl.sv
// Controller for the encoder period tachometer: sequences a tick through
// phase update, divisor multiply, serial divide and output load.
// Depends on ept_pkg.
`timescale 1ns / 1ps

module ept_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ept_pkg::status_t st_i,
  output ept_pkg::cmd_t   cmd_o
);
  import ept_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.step    = 1'b1;
          cmd_o.out_tmo = st_i.tmo;
          if (st_i.meas) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_meas = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_tmo || cmd_o.out_meas) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/ept_datapath.sv
// Datapath for the encoder period tachometer: configuration registers,
// phase and tick counters, divisor multiply, restoring divider, output register.
// Depends on ept_pkg.
`timescale 1ns / 1ps

module ept_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ept_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [ept_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       encoder_level_i,
  input  ept_pkg::cmd_t              cmd_i,
  output ept_pkg::status_t           st_o,
  output logic [ept_pkg::RPM_W-1:0]  rpm_o,
  output logic                       timed_out_o
);
  import ept_pkg::*;

  logic [PPR_W-1:0]       ppr_q;
  logic [TMO_W-1:0]       tmo_q;
  logic [TPM_W-1:0]       tpm_q;

  phase_e                 phase_q, phase_d;
  logic [TMO_W-1:0]       elapsed_q, elapsed_d;
  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic [PERIOD_BITS-1:0] meas_q, meas_d;

  logic [PRODW-1:0]       dvs_q;
  logic [PRODW-1:0]       rem_q;
  logic [TPM_W-1:0]       quo_q;
  logic [CNT_W-1:0]       cnt_q;

  logic [RPM_W-1:0]       rpm_q;
  logic                   timed_out_q;

  logic [PERIOD_BITS-1:0] pc_inc;
  logic                   cond_met;
  logic [PPR_W-1:0]       ppr_eff;
  logic [PRODW:0]         shifted;
  logic                   qbit;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= PPR_RESET;
      tmo_q <= TMO_RESET;
      tpm_q <= TPM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PPR: ppr_q <= cfg_data_i[PPR_W-1:0];
        REG_TMO: tmo_q <= cfg_data_i[TMO_W-1:0];
        REG_TPM: tpm_q <= cfg_data_i[TPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase logic
  always_comb begin
    if ((phase_q inside {PH_WAIT_HIGH1, PH_WAIT_FALL1}) && period_q != PERIOD_MAX) begin
      pc_inc = period_q + PERIOD_BITS'(1);
    end else begin
      pc_inc = period_q;
    end
    case (phase_q)
      PH_WAIT_HIGH0: cond_met = encoder_level_i;
      PH_WAIT_FALL0: cond_met = !encoder_level_i;
      PH_WAIT_HIGH1: cond_met = encoder_level_i;
      PH_WAIT_FALL1: cond_met = !encoder_level_i;
      default:       cond_met = 1'b0;
    endcase
  end

  assign st_o.tmo      = !cond_met && (elapsed_q >= tmo_q);
  assign st_o.meas     = cond_met && (phase_q == PH_WAIT_FALL1);
  assign st_o.div_last = (cnt_q == CNT_W'(TPM_W - 1));

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    period_d  = period_q;
    meas_d    = meas_q;
    if (cmd_i.step) begin
      if (st_o.tmo) begin
        phase_d   = PH_WAIT_HIGH0;
        elapsed_d = '0;
        period_d  = '0;
      end else if (cond_met) begin
        elapsed_d = '0;
        case (phase_q)
          PH_WAIT_HIGH0: phase_d = PH_WAIT_FALL0;
          PH_WAIT_FALL0: begin
            phase_d  = PH_WAIT_HIGH1;
            period_d = '0;
          end
          PH_WAIT_HIGH1: begin
            phase_d  = PH_WAIT_FALL1;
            period_d = pc_inc;
          end
          PH_WAIT_FALL1: begin
            phase_d  = PH_WAIT_HIGH0;
            period_d = '0;
            meas_d   = (pc_inc == '0) ? PERIOD_BITS'(1) : pc_inc;
          end
          default: phase_d = PH_WAIT_HIGH0;
        endcase
      end else begin
        elapsed_d = elapsed_q + TMO_W'(1);
        period_d  = pc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_HIGH0;
      elapsed_q <= '0;
      period_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      period_q  <= period_d;
    end
  end

  // Divisor multiply and restoring divide, one quotient bit per cycle
  assign ppr_eff = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
  assign shifted = {rem_q, quo_q[TPM_W-1]};
  assign qbit    = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    meas_q <= meas_d;
    if (cmd_i.mul) begin
      dvs_q <= PRODW'(meas_q) * PRODW'(ppr_eff);
      rem_q <= '0;
      quo_q <= tpm_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? PRODW'(shifted - {1'b0, dvs_q}) : shifted[PRODW-1:0];
      quo_q <= {quo_q[TPM_W-2:0], qbit};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.out_tmo) begin
      rpm_q       <= '0;
      timed_out_q <= 1'b1;
    end else if (cmd_i.out_meas) begin
      rpm_q       <= quo_q;
      timed_out_q <= 1'b0;
    end
  end

  assign rpm_o       = rpm_q;
  assign timed_out_o = timed_out_q;

endmodule
